@@ rtl/core/spr_pkg.sv @@
// ----------------------------------------------------------------------------
// Servo pulse relay switch - shared definitions
// Register indexes, reset values, fixed constants and the structs passed
// between the configuration block, the datapath and the top level.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_MIDPOINT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_RELAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BAND        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SETUP_SPAN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_TIMEOUT      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_DIVIDER      = 3'd7;

    localparam logic [7:0]  RST_INITIAL_MIDPOINT = 8'd94;
    localparam logic        RST_INITIAL_RELAY    = 1'b0;
    localparam logic [7:0]  RST_PULSE_MAX        = 8'd168;
    localparam logic [7:0]  RST_PULSE_MIN        = 8'd20;
    localparam logic [5:0]  RST_HALF_BAND        = 6'd2;
    localparam logic [6:0]  RST_MIN_SETUP_SPAN   = 7'd4;
    localparam logic [11:0] RST_LOW_TIMEOUT      = 12'd2500;
    localparam logic [7:0]  RST_LED_DIVIDER      = 8'd4;

    localparam logic [7:0] MID_DEFAULT    = 8'd94;
    localparam logic [2:0] DEBOUNCE_LIMIT = 3'd5;
    localparam logic [4:0] ERROR_HOLD     = 5'd20;
    localparam logic [4:0] LED_BEATS      = 5'd16;

    localparam logic ACT_PULSE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    typedef struct packed {
        logic [7:0]  initial_midpoint;
        logic        initial_relay;
        logic [7:0]  pulse_max;
        logic [7:0]  pulse_min;
        logic [5:0]  half_band;
        logic [6:0]  min_setup_span;
        logic [11:0] low_timeout;
        logic [7:0]  led_divider;
    } cfg_t;

    typedef struct packed {
        logic       relay_on;
        logic       led_on;
        logic       relay_store;
        logic       midpoint_store;
        logic [7:0] midpoint_value;
        logic       no_signal;
        logic       setup_mode;
        logic       error_mode;
    } res_t;

endpackage

@@ rtl/core/servo_pulse_relay_switch.sv @@
// ----------------------------------------------------------------------------
// Servo pulse relay switch - top level
// Input register, state update and result register for a servo-driven relay
// with hysteresis, setup learning, LED status pattern and low-line timeout.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  action, pulse_width, setup_link
//   out      out_valid/ out_stall relay_on, led_on, relay_store, midpoint_store,
//                                 midpoint_value, no_signal, setup_mode, error_mode
//   cfg      cfg_we               cfg_index, cfg_data
//
// One beat per cycle sustained while out_stall is low; a result goes through the input
// register, then the result register, before it is valid at the output.
// The state update is one short combinational pass between the two registers.
// Reset clears the valid flags and the core state and loads the register defaults; no clearing pass.
// out_stall holds the result register and, once the input register is full,
// raises in_stall in the same cycle.
// ----------------------------------------------------------------------------
module servo_pulse_relay_switch (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [spr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           action,
    input  logic [7:0]                     pulse_width,
    input  logic                           setup_link,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           relay_on,
    output logic                           led_on,
    output logic                           relay_store,
    output logic                           midpoint_store,
    output logic [7:0]                     midpoint_value,
    output logic                           no_signal,
    output logic                           setup_mode,
    output logic                           error_mode
);
    import spr_pkg::*;

    cfg_t       cfg;
    res_t       res;
    res_t       res_reg;
    logic       out_valid_reg;
    logic       s1_valid_reg;
    logic       action_reg;
    logic [7:0] width_reg;
    logic       link_reg;
    logic       advance;
    logic       step;
    logic       take;

    assign advance  = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    spr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spr_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .step        (step),
        .action      (action_reg),
        .pulse_width (width_reg),
        .setup_link  (link_reg),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            action_reg <= action;
            width_reg  <= pulse_width;
            link_reg   <= setup_link;
        end
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign relay_on       = res_reg.relay_on;
    assign led_on         = res_reg.led_on;
    assign relay_store    = res_reg.relay_store;
    assign midpoint_store = res_reg.midpoint_store;
    assign midpoint_value = res_reg.midpoint_value;
    assign no_signal      = res_reg.no_signal;
    assign setup_mode     = res_reg.setup_mode;
    assign error_mode     = res_reg.error_mode;

endmodule

@@ rtl/core/spr_cfg.sv @@
// ----------------------------------------------------------------------------
// Servo pulse relay switch - configuration registers
// Write-only register file, indexed writes from the configuration port.
// ----------------------------------------------------------------------------
module spr_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [spr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0] cfg_data,
    output spr_pkg::cfg_t                  cfg
);
    import spr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_midpoint <= RST_INITIAL_MIDPOINT;
            cfg_reg.initial_relay    <= RST_INITIAL_RELAY;
            cfg_reg.pulse_max        <= RST_PULSE_MAX;
            cfg_reg.pulse_min        <= RST_PULSE_MIN;
            cfg_reg.half_band        <= RST_HALF_BAND;
            cfg_reg.min_setup_span   <= RST_MIN_SETUP_SPAN;
            cfg_reg.low_timeout      <= RST_LOW_TIMEOUT;
            cfg_reg.led_divider      <= RST_LED_DIVIDER;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INITIAL_MIDPOINT: cfg_reg.initial_midpoint <= cfg_data[7:0];
                CFG_INITIAL_RELAY:    cfg_reg.initial_relay    <= cfg_data[0];
                CFG_PULSE_MAX:        cfg_reg.pulse_max        <= cfg_data[7:0];
                CFG_PULSE_MIN:        cfg_reg.pulse_min        <= cfg_data[7:0];
                CFG_HALF_BAND:        cfg_reg.half_band        <= cfg_data[5:0];
                CFG_MIN_SETUP_SPAN:   cfg_reg.min_setup_span   <= cfg_data[6:0];
                CFG_LOW_TIMEOUT:      cfg_reg.low_timeout      <= cfg_data[11:0];
                CFG_LED_DIVIDER:      cfg_reg.led_divider      <= cfg_data[7:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/spr_core.sv @@
// ----------------------------------------------------------------------------
// Servo pulse relay switch - state update
// Holds the switch state and works out one beat's result and next state:
// start-up load, hysteresis compare, setup learning, LED pattern, low timeout.
// ----------------------------------------------------------------------------
module spr_core (
    input  logic          clk,
    input  logic          rst_n,
    input  spr_pkg::cfg_t cfg,
    input  logic          step,
    input  logic          action,
    input  logic [7:0]    pulse_width,
    input  logic          setup_link,
    output spr_pkg::res_t res
);
    import spr_pkg::*;

    logic       started_reg,    started_next;
    logic       relay_reg,      relay_next;
    logic [7:0] midpoint_reg,   midpoint_next;
    logic [7:0] saved_reg,      saved_next;
    logic       setup_reg,      setup_next;
    logic [2:0] debounce_reg,   debounce_next;
    logic       error_reg,      error_next;
    logic [4:0] countdown_reg,  countdown_next;
    logic [7:0] led_tick_reg,   led_tick_next;
    logic [4:0] led_beat_reg,   led_beat_next;
    logic       led_level_reg,  led_level_next;
    logic       nosig_reg,      nosig_next;
    logic [11:0] low_count_reg, low_count_next;

    logic        mid_bad;
    logic [7:0]  mid0;
    logic        relay0;
    logic        pulse_item;
    logic        over_max;
    logic [7:0]  thr;
    logic        want;
    logic [12:0] low_inc;
    logic        timeout_hit;
    logic        led_go;
    logic        led_nosig;
    logic [7:0]  tick_inc;
    logic [4:0]  beat_inc;
    logic        busy;
    logic        setup_go;
    logic signed [7:0] diff;
    logic [7:0]  mag_full;
    logic [6:0]  mag;
    logic        learn;
    logic        rstore;

    assign mid_bad    = (cfg.initial_midpoint >= cfg.pulse_max) ||
                        (cfg.initial_midpoint <= cfg.pulse_min);
    assign mid0       = started_reg ? midpoint_reg
                                    : (mid_bad ? MID_DEFAULT : cfg.initial_midpoint);
    assign relay0     = started_reg ? relay_reg : cfg.initial_relay;
    assign pulse_item = (action == ACT_PULSE);
    assign over_max   = pulse_width > cfg.pulse_max;
    assign thr        = relay0 ? (mid0 - {2'b00, cfg.half_band})
                               : (mid0 + {2'b00, cfg.half_band});
    assign want       = pulse_width > thr;
    assign low_inc    = {1'b0, low_count_reg} + 13'd1;
    assign timeout_hit = (action == ACT_TICK) && (low_inc > {1'b0, cfg.low_timeout});
    assign led_go     = pulse_item || timeout_hit;
    assign led_nosig  = !pulse_item || over_max;
    assign tick_inc   = led_tick_reg + 8'd1;
    assign beat_inc   = led_beat_reg + 5'd1;
    assign busy       = setup_reg | error_reg;
    assign setup_go   = pulse_item && !over_max;
    assign diff       = $signed({1'b0, pulse_width[7:1]}) - $signed({1'b0, saved_reg[7:1]});
    assign mag_full   = diff[7] ? (8'd0 - diff) : diff;
    assign mag        = mag_full[6:0];
    assign learn      = setup_go && !setup_link && setup_reg && (mag > cfg.min_setup_span);
    assign rstore     = setup_go && (want != relay0);

    always_comb
    begin
        started_next   = 1'b1;
        relay_next     = setup_go ? want : relay0;
        midpoint_next  = learn ? (saved_reg + diff) : mid0;
        saved_next     = saved_reg;
        setup_next     = setup_reg;
        debounce_next  = debounce_reg;
        error_next     = error_reg;
        countdown_next = countdown_reg;
        led_tick_next  = led_tick_reg;
        led_beat_next  = led_beat_reg;
        led_level_next = led_level_reg;
        nosig_next     = nosig_reg;
        low_count_next = low_count_reg;

        // low line counter
        if (pulse_item)
        begin
            low_count_next = '0;
        end
        else if (timeout_hit)
        begin
            low_count_next = '0;
        end
        else
        begin
            low_count_next = low_inc[11:0];
        end

        // LED pattern; uses setup/error flags from before this beat
        if (led_go)
        begin
            nosig_next = led_nosig;
            if (tick_inc <= cfg.led_divider)
            begin
                led_tick_next = tick_inc;
            end
            else
            begin
                led_tick_next = '0;
                led_beat_next = beat_inc;
                case (beat_inc) inside
                    5'd1:           led_level_next = 1'b1;
                    [5'd2:5'd3]:    led_level_next = busy;
                    5'd4:           led_level_next = relay_next | busy;
                    [5'd5:5'd9]:    led_level_next = busy;
                    [5'd10:5'd13]:  led_level_next = led_nosig | error_reg;
                    [5'd14:5'd15]:  led_level_next = error_reg;
                    LED_BEATS:
                    begin
                        led_level_next = 1'b0;
                        led_beat_next  = '0;
                    end
                    default:        led_level_next = led_level_reg;
                endcase
            end
        end

        // setup link handling
        if (setup_go)
        begin
            if (countdown_reg != '0)
            begin
                countdown_next = countdown_reg - 5'd1;
            end
            else
            begin
                error_next = 1'b0;
            end
            if (setup_link)
            begin
                if (debounce_reg < DEBOUNCE_LIMIT)
                begin
                    debounce_next = debounce_reg + 3'd1;
                end
                else if (!setup_reg)
                begin
                    saved_next = pulse_width;
                    setup_next = 1'b1;
                end
            end
            else
            begin
                if (setup_reg && !learn)
                begin
                    countdown_next = ERROR_HOLD;
                    error_next     = 1'b1;
                end
                setup_next    = 1'b0;
                debounce_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            relay_reg     <= 1'b0;
            midpoint_reg  <= '0;
            saved_reg     <= '0;
            setup_reg     <= 1'b0;
            debounce_reg  <= '0;
            error_reg     <= 1'b0;
            countdown_reg <= '0;
            led_tick_reg  <= '0;
            led_beat_reg  <= '0;
            led_level_reg <= 1'b0;
            nosig_reg     <= 1'b0;
            low_count_reg <= '0;
        end
        else if (step)
        begin
            started_reg   <= started_next;
            relay_reg     <= relay_next;
            midpoint_reg  <= midpoint_next;
            saved_reg     <= saved_next;
            setup_reg     <= setup_next;
            debounce_reg  <= debounce_next;
            error_reg     <= error_next;
            countdown_reg <= countdown_next;
            led_tick_reg  <= led_tick_next;
            led_beat_reg  <= led_beat_next;
            led_level_reg <= led_level_next;
            nosig_reg     <= nosig_next;
            low_count_reg <= low_count_next;
        end
    end

    always_comb
    begin
        res.relay_on       = relay_next;
        res.led_on         = led_level_next;
        res.relay_store    = rstore;
        res.midpoint_store = (!started_reg && mid_bad) || learn;
        res.midpoint_value = midpoint_next;
        res.no_signal      = nosig_next;
        res.setup_mode     = setup_next;
        res.error_mode     = error_next;
    end

endmodule
